FILE: design/ufr_pkg.sv
// Shared types and constants for the UBX frame receiver.
package ufr_pkg;

    // Largest frame accepted, sync bytes and checksum included.
    localparam int unsigned MAX_FRAME_BYTES = 256;

    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [15:0] HDR_BYTES   = 16'd4;
    localparam logic [15:0] SUM_BYTES   = 16'd2;
    localparam logic [15:0] SYNC_BYTES  = 16'd2;

    // Overhead added to the declared payload length, and the frame limit, on 17 bits.
    localparam logic [16:0] FRAME_OVERHEAD = 17'(HDR_BYTES + SUM_BYTES + SYNC_BYTES);
    localparam logic [16:0] FRAME_LIMIT    = 17'(MAX_FRAME_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SUM     = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CLASS    = 3'd0,
        KIND_ID       = 3'd1,
        KIND_LEN_LOW  = 3'd2,
        KIND_LEN_HIGH = 3'd3,
        KIND_PAYLOAD  = 3'd4,
        KIND_END      = 3'd5,
        KIND_DROP     = 3'd6
    } kind_t;

endpackage

FILE: design/ubx_frame_receiver.sv
// UBX frame receiver: sync hunt, header and payload echo, oversized-frame drop, Fletcher checksum check.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_rx_byte             | in
//  result  | m_valid, m_ready, m_out_byte,           | out
//          | m_byte_kind, m_payload_index,           |
//          | m_payload_length, m_checksum_ok,        |
//          | m_frame_last                            |
//
// One byte is taken per clock cycle while no waiting result holds the input; the
// parse state, the Fletcher sums and, on a result byte, the output register all
// update at the edge of the input beat, so a result can be taken in the cycle
// after the byte that caused it. A byte is taken while a result waits as long as
// that result is taken in the same cycle. Reset (synchronous, aresetn low) returns
// the parser to the sync hunt and drops any pending result.
module ubx_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [2:0]  m_byte_kind,
    output logic [7:0]  m_payload_index,
    output logic [15:0] m_payload_length,
    output logic        m_checksum_ok,
    output logic        m_frame_last
);
    import ufr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rx_sum_a_reg, rx_sum_a_next;
    logic [7:0]  len_low_reg, len_low_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  index_reg, index_next;
    logic [15:0] out_len_reg, out_len_next;
    logic        ok_reg, ok_next;
    logic        last_reg, last_next;

    logic        in_beat;
    logic        emit;
    logic [1:0]  hdr_idx;
    logic [7:0]  sum_a_add;
    logic [15:0] new_length;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    // Running sum A with the current byte folded in.
    assign sum_a_add  = sum_a_reg + s_rx_byte;
    assign hdr_idx    = 2'(2'd0 - countdown_reg[1:0]);
    assign new_length = {s_rx_byte, len_low_reg};

    // Next parse state and the result caused by the current byte.
    always_comb begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        length_next    = length_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        rx_sum_a_next  = rx_sum_a_reg;
        len_low_next   = len_low_reg;
        emit           = 1'b0;
        out_byte_next  = s_rx_byte;
        kind_next      = KIND_CLASS;
        index_next     = 8'd0;
        out_len_next   = 16'd0;
        ok_next        = 1'b0;
        last_next      = 1'b0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (s_rx_byte == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (s_rx_byte == SYNC_SECOND) begin
                    phase_next     = PH_HEADER;
                    countdown_next = HDR_BYTES;
                    sum_a_next     = 8'd0;
                    sum_b_next     = 8'd0;
                end else if (s_rx_byte != SYNC_FIRST) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_HEADER: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                emit       = 1'b1;
                if (hdr_idx == 2'd2) begin
                    len_low_next = s_rx_byte;
                end
                if (hdr_idx != 2'd3) begin
                    countdown_next = 16'(HDR_BYTES - 16'(hdr_idx) - 16'd1);
                    kind_next      = kind_t'({1'b0, hdr_idx});
                end else begin
                    length_next  = new_length;
                    out_len_next = new_length;
                    if (({1'b0, new_length} + FRAME_OVERHEAD) > FRAME_LIMIT) begin
                        // Frame cannot fit: report a drop and hunt again.
                        phase_next     = PH_HUNT;
                        countdown_next = 16'd0;
                        out_byte_next  = 8'd0;
                        kind_next      = KIND_DROP;
                        last_next      = 1'b1;
                    end else begin
                        kind_next = KIND_LEN_HIGH;
                        if (new_length == 16'd0) begin
                            // Empty payload goes straight to the checksum.
                            phase_next     = PH_SUM;
                            countdown_next = SUM_BYTES;
                        end else begin
                            phase_next     = PH_PAYLOAD;
                            countdown_next = new_length;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                sum_a_next   = sum_a_add;
                sum_b_next   = sum_b_reg + sum_a_add;
                emit         = 1'b1;
                kind_next    = KIND_PAYLOAD;
                index_next   = 8'(length_reg - countdown_reg);
                out_len_next = length_reg;
                if (countdown_reg <= 16'd1) begin
                    phase_next     = PH_SUM;
                    countdown_next = SUM_BYTES;
                end else begin
                    countdown_next = countdown_reg - 16'd1;
                end
            end
            PH_SUM: begin
                if (countdown_reg > 16'd1) begin
                    rx_sum_a_next  = s_rx_byte;
                    countdown_next = 16'd1;
                end else begin
                    phase_next     = PH_HUNT;
                    countdown_next = 16'd0;
                    emit           = 1'b1;
                    out_byte_next  = 8'd0;
                    kind_next      = KIND_END;
                    out_len_next   = length_reg;
                    ok_next        = (rx_sum_a_reg == sum_a_reg) && (s_rx_byte == sum_b_reg);
                    last_next      = 1'b1;
                end
            end
            default: begin
                phase_next     = PH_HUNT;
                countdown_next = 16'd0;
            end
        endcase
    end

    // Output valid: cleared when taken, set when a beat produces a result.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (in_beat && emit) begin
            m_valid_next = 1'b1;
        end
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            countdown_reg <= 16'd0;
            length_reg    <= 16'd0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            rx_sum_a_reg  <= 8'd0;
            len_low_reg   <= 8'd0;
        end else if (in_beat) begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            length_reg    <= length_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            rx_sum_a_reg  <= rx_sum_a_next;
            len_low_reg   <= len_low_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (in_beat && emit) begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= kind_next;
            index_reg    <= index_next;
            out_len_reg  <= out_len_next;
            ok_reg       <= ok_next;
            last_reg     <= last_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_byte_kind      = kind_reg;
    assign m_payload_index  = index_reg;
    assign m_payload_length = out_len_reg;
    assign m_checksum_ok    = ok_reg;
    assign m_frame_last     = last_reg;

`ifndef ASSERT_OFF
    // A result that closes a frame is always an end or a drop.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> (kind_reg == KIND_END || kind_reg == KIND_DROP))
        else $error("frame_last on a result that is not end or drop");

    // Only end results carry a set checksum flag.
    a_ok_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> kind_reg == KIND_END)
        else $error("checksum_ok set on a non-end result");

    // A byte taken while hunting leaves the parser hunting or awaiting the second sync byte.
    a_hunt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && phase_reg == PH_HUNT |=> (phase_reg == PH_HUNT || phase_reg == PH_SYNC2))
        else $error("parser left the hunt without a sync byte");

    // A frame end or drop result sends the parser back to the hunt.
    a_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && emit && last_next |=> phase_reg == PH_HUNT && m_valid)
        else $error("parser did not resync after end or drop");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the UBX frame receiver: sync hunt, echo, checksum and drop.
`timescale 1ns / 100ps

module tb_top;
    import ufr_pkg::*;

    localparam int unsigned SINK_HOLD_CYCLES = 40;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned MAX_PAYLOAD      = MAX_FRAME_BYTES - 8;

    // One expected result beat.
    typedef struct packed {
        logic [7:0]  out_byte;
        kind_t       kind;
        logic [7:0]  index;
        logic [15:0] length;
        logic        ok;
        logic        last;
    } frame_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_out_byte;
    logic [2:0]  m_byte_kind;
    logic [7:0]  m_payload_index;
    logic [15:0] m_payload_length;
    logic        m_checksum_ok;
    logic        m_frame_last;

    // Parser state mirrored by the predictor.
    phase_t      rx_phase    = PH_HUNT;
    logic [15:0] bytes_left  = '0;
    logic [15:0] frame_len   = '0;
    logic [7:0]  fletcher_a  = '0;
    logic [7:0]  fletcher_b  = '0;
    logic [7:0]  rx_sum_a    = '0;
    logic [7:0]  len_low     = '0;

    frame_result_t pending_results[$];

    bit          idle_on   = 1'b1;
    bit          hold_sink = 1'b0;
    int unsigned errors        = 0;
    int unsigned bytes_sent    = 0;
    int unsigned parsed_bytes  = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_good   = 0;
    int unsigned frames_bad    = 0;
    int unsigned frames_dropped = 0;

    ubx_frame_receiver DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_kind      (m_byte_kind),
        .m_payload_index  (m_payload_index),
        .m_payload_length (m_payload_length),
        .m_checksum_ok    (m_checksum_ok),
        .m_frame_last     (m_frame_last)
    );

    always #1 aclk = ~aclk;

    // Advance the mirrored parser by one accepted byte and queue any result it causes.
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic [1:0]  hdr_idx;
        logic [15:0] pay_idx;
        logic        sums_match;
        if (rx_phase != PH_HUNT) begin
            parsed_bytes++;
        end
        case (rx_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) rx_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    rx_phase   = PH_HEADER;
                    bytes_left = HDR_BYTES;
                    fletcher_a = '0;
                    fletcher_b = '0;
                end else if (b != SYNC_FIRST) begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_HEADER: begin
                hdr_idx    = 2'(HDR_BYTES - bytes_left);
                fletcher_a = fletcher_a + b;
                fletcher_b = fletcher_b + fletcher_a;
                if (hdr_idx == 2'd2) len_low = b;
                if (hdr_idx < 2'd3) begin
                    bytes_left = HDR_BYTES - 16'(hdr_idx) - 16'd1;
                    pending_results.push_back('{b, kind_t'({1'b0, hdr_idx}), 8'd0, 16'd0,
                                                1'b0, 1'b0});
                end else begin
                    frame_len = {b, len_low};
                    if ({1'b0, frame_len} + FRAME_OVERHEAD > FRAME_LIMIT) begin
                        rx_phase   = PH_HUNT;
                        bytes_left = '0;
                        pending_results.push_back('{8'd0, KIND_DROP, 8'd0, frame_len,
                                                    1'b0, 1'b1});
                    end else begin
                        if (frame_len == 16'd0) begin
                            rx_phase   = PH_SUM;
                            bytes_left = SUM_BYTES;
                        end else begin
                            rx_phase   = PH_PAYLOAD;
                            bytes_left = frame_len;
                        end
                        pending_results.push_back('{b, KIND_LEN_HIGH, 8'd0, frame_len,
                                                    1'b0, 1'b0});
                    end
                end
            end
            PH_PAYLOAD: begin
                pay_idx    = frame_len - bytes_left;
                fletcher_a = fletcher_a + b;
                fletcher_b = fletcher_b + fletcher_a;
                if (bytes_left <= 16'd1) begin
                    rx_phase   = PH_SUM;
                    bytes_left = SUM_BYTES;
                end else begin
                    bytes_left = bytes_left - 16'd1;
                end
                pending_results.push_back('{b, KIND_PAYLOAD, pay_idx[7:0], frame_len,
                                            1'b0, 1'b0});
            end
            PH_SUM: begin
                if (bytes_left > 16'd1) begin
                    rx_sum_a   = b;
                    bytes_left = 16'd1;
                end else begin
                    sums_match = (rx_sum_a == fletcher_a) && (b == fletcher_b);
                    rx_phase   = PH_HUNT;
                    bytes_left = '0;
                    pending_results.push_back('{8'd0, KIND_END, 8'd0, frame_len,
                                                sums_match, 1'b1});
                end
            end
            default: begin
                rx_phase   = PH_HUNT;
                bytes_left = '0;
            end
        endcase
    endfunction

    // Predict on every accepted input beat.
    always @(posedge aclk) begin : input_monitor
        if (aresetn && s_valid && s_ready) begin
            parse_rx_byte(s_rx_byte);
        end
    end

    // Report one field that differs from its expectation.
    function automatic bit field_differs(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                     $time, name, want, want, got, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with none expected: byte=0x%h kind=%0d",
                         $time, m_out_byte, m_byte_kind);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (field_differs("out_byte", 16'(want.out_byte), 16'(m_out_byte))
                    | field_differs("byte_kind", 16'(want.kind), 16'(m_byte_kind))
                    | field_differs("payload_index", 16'(want.index), 16'(m_payload_index))
                    | field_differs("payload_length", want.length, m_payload_length)
                    | field_differs("checksum_ok", 16'(want.ok), 16'(m_checksum_ok))
                    | field_differs("frame_last", 16'(want.last), 16'(m_frame_last))) begin
                    errors++;
                end
                if (want.kind == KIND_END) begin
                    if (want.ok) frames_good++;
                    else frames_bad++;
                end
                if (want.kind == KIND_DROP) frames_dropped++;
            end
        end
    end

    // Result-side ready: random short stalls, plus a long hold when asked for.
    initial begin : sink_ready
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                hold_sink = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Stop offering and wait until every expected result beat has come out.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Send a complete frame; bit 0 / bit 1 of sum_err corrupt the first / second
    // checksum byte. An oversized length ends the frame after the header.
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg_id,
                              input logic [15:0] len, input logic [1:0] sum_err);
        logic [7:0] hdr [4];
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] pb;
        hdr[0] = cls;
        hdr[1] = msg_id;
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        ca = '0;
        cb = '0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < 4; i++) begin
            send_byte(hdr[i]);
            ca = ca + hdr[i];
            cb = cb + ca;
        end
        if ({1'b0, len} + FRAME_OVERHEAD > FRAME_LIMIT) return;
        for (int i = 0; i < int'(len); i++) begin
            pb = 8'($urandom);
            send_byte(pb);
            ca = ca + pb;
            cb = cb + ca;
        end
        send_byte(sum_err[0] ? ca ^ 8'($urandom_range(1, 255)) : ca);
        send_byte(sum_err[1] ? cb ^ 8'($urandom_range(1, 255)) : cb);
    endtask

    // Noise while hunting, a broken sync pair, a repeated first sync byte,
    // an empty payload and the smallest oversized length.
    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(SYNC_FIRST);
        send_frame(8'hFF, 8'h00, 16'd0, 2'b00);
        send_frame(8'h00, 8'hFF, 16'(MAX_PAYLOAD + 1), 2'b00);
    endtask

    // Largest payload, largest declared length and corrupted checksum bytes.
    task automatic test_length_extremes();
        send_frame(8'hA5, 8'h5A, 16'(MAX_PAYLOAD), 2'b00);
        send_frame(8'h01, 8'h02, 16'hFFFF, 2'b00);
        send_frame(8'h06, 8'h04, 16'hFF00, 2'b00);
        send_frame(8'h0A, 8'h0B, 16'd1, 2'b01);
        send_frame(8'h0C, 8'h0D, 16'd1, 2'b10);
        send_frame(8'h0E, 8'h0F, 16'd3, 2'b11);
    endtask

    // Mostly well-formed frames with random content, mixed with noise and broken frames.
    task automatic test_random_frames(input int unsigned target);
        int unsigned start;
        int unsigned pick;
        logic [15:0] len;
        start = parsed_bytes;
        while (parsed_bytes < start + target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 29) == 0) len = 16'($urandom_range(17, MAX_PAYLOAD));
                else len = 16'($urandom_range(0, 16));
                send_frame(8'($urandom), 8'($urandom), len,
                           ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
            end else if (pick < 80) begin
                send_frame(8'($urandom), 8'($urandom),
                           16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF)), 2'b00);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end else begin
                // A frame cut short: the next bytes are parsed as its continuation.
                send_byte(SYNC_FIRST);
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(8'($urandom));
                end else begin
                    send_byte(SYNC_SECOND);
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
                end
            end
        end
    endtask

    // Hold the result side off long enough for the block to stall its input.
    task automatic test_output_stall();
        hold_sink = 1'b1;
        send_frame(8'h21, 8'h42, 16'd24, 2'b00);
        pause_until_drained();
    endtask

    // Frames separated by pauses in which every result drains.
    task automatic test_drain_pause();
        repeat (4) begin
            send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 12)), 2'b00);
            pause_until_drained();
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_back_to_back(input int unsigned target);
        idle_on = 1'b0;
        test_random_frames(target);
    endtask

    initial begin : main
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_length_extremes();
        test_output_stall();
        test_random_frames(550);
        test_drain_pause();
        test_back_to_back(120);
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d bytes (%0d inside frames) and checked %0d result beats.",
                 bytes_sent, parsed_bytes, results_seen);
        $display("Frames ending with good checksum: %0d, bad checksum: %0d, dropped: %0d.",
                 frames_good, frames_bad, frames_dropped);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d result beats still expected.", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: ubx_frame_receiver.f
design/ufr_pkg.sv
design/ubx_frame_receiver.sv
tb/sv/tb_top.sv
